/* hdl/ipv4_route_table_lookup_top_defines.svh */
// Assertion macros used by the route lookup top module.
// Both sample on clk and are disabled while rst is high.
`ifndef IPV4_ROUTE_TABLE_LOOKUP_TOP_DEFINES_SVH
`define IPV4_ROUTE_TABLE_LOOKUP_TOP_DEFINES_SVH

// Same-cycle implication.
`define RTLK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RTLK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/rtlk_pkg.sv */
`default_nettype none

package rtlk_pkg;

  localparam int ENTRIES_DEF = 8;
  localparam int PORTS_DEF   = 16;

  localparam int OCTET_BITS  = 8;
  localparam int ADDR_OCTETS = 4;

  localparam int ADDR_W = 32;
  localparam int SLOT_W = 3;
  localparam int LEN_W  = 6;
  localparam int PORT_W = 4;
  localparam int OCT_W  = 3;

  typedef enum logic {
    ACT_LOOKUP = 1'b0,
    ACT_WRITE  = 1'b1
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [ADDR_W-1:0]   address;
    logic [SLOT_W-1:0]   entry_slot;
    logic [LEN_W-1:0]    prefix_length;
    logic                gateway_given;
    logic [ADDR_W-1:0]   gateway_address;
    logic [PORT_W-1:0]   egress_port;
    logic                entry_enable;
  } in_t;

  typedef struct packed {
    logic                for_self;
    logic                route_found;
    logic [SLOT_W-1:0]   matched_slot;
    logic [PORT_W-1:0]   out_port;
    logic [ADDR_W-1:0]   next_hop;
  } out_t;

  // One stored route.
  typedef struct packed {
    logic [ADDR_W-1:0]   prefix;
    logic [OCT_W-1:0]    octets;
    logic                has_gw;
    logic [ADDR_W-1:0]   gateway;
    logic [PORT_W-1:0]   port;
  } entry_t;

  // Table write request.
  typedef struct packed {
    logic                en;
    logic [SLOT_W-1:0]   slot;
    logic                mark;
    entry_t              entry;
  } wr_t;

endpackage

`default_nettype wire

/* hdl/ipv4_route_table_lookup_top.sv */
// Channel   Direction  Handshake            Beat
// in        input      in_valid / in_stall  in_data  (rtlk_pkg::in_t)
// out       output     out_valid / out_stall out_data (rtlk_pkg::out_t)
// cfg       input      cfg_valid / cfg_ready cfg_data (own address)
//
// A lookup walks the table one entry per cycle through a single masked
// compare unit fed by the table's one read port and stops at the first
// hit. Writes and own-address hits skip the scan. in_stall is high while
// an item is being worked on.
// Synchronous reset clears the sequencer, the valid marks and own_address.
// A result waits in the output register while out_stall is high; the next
// beat may be accepted meanwhile.
`default_nettype none

module ipv4_route_table_lookup_top #(
  parameter int ENTRIES = rtlk_pkg::ENTRIES_DEF,
  parameter int PORTS   = rtlk_pkg::PORTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire rtlk_pkg::in_t               in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output rtlk_pkg::out_t                   out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [rtlk_pkg::ADDR_W-1:0] cfg_data
);
  import rtlk_pkg::*;
  `include "ipv4_route_table_lookup_top_defines.svh"

  localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = SW + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [ADDR_W-1:0] own_address;
  logic [ADDR_W-1:0] dest, dest_next;
  logic [CW-1:0]     rd_cnt, rd_cnt_next;
  logic              cmp_vld, cmp_vld_next;
  logic [SW-1:0]     cmp_idx, cmp_idx_next;
  out_t              pend, pend_next;
  logic              load;

  wr_t               wr;
  entry_t            rd_entry;
  logic              rd_valid;
  logic              hit;

  logic              self_route;
  logic              miss_clean;
  logic              done_held;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Table write, taken straight from the accepted beat.
  always_comb begin
    wr              = '0;
    wr.en           = in_valid && !in_stall && (in_data.action == ACT_WRITE)
                      && (int'(in_data.entry_slot) < ENTRIES);
    wr.slot         = in_data.entry_slot;
    wr.mark         = in_data.entry_enable;
    wr.entry.prefix = in_data.address;
    wr.entry.octets = in_data.prefix_length[LEN_W-1]
                      ? OCT_W'(ADDR_OCTETS)
                      : {1'b0, in_data.prefix_length[LEN_W-2:LEN_W-3]};
    wr.entry.has_gw  = in_data.gateway_given;
    wr.entry.gateway = in_data.gateway_address;
    wr.entry.port    = (int'(in_data.egress_port) >= PORTS)
                       ? PORT_W'(PORTS - 1) : in_data.egress_port;
  end

  rtlk_table #(
    .ENTRIES (ENTRIES),
    .SW      (SW)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd_addr  (rd_cnt[SW-1:0]),
    .rd_entry (rd_entry),
    .rd_valid (rd_valid)
  );

  rtlk_cmp u_cmp (
    .addr  (dest),
    .entry (rd_entry),
    .valid (rd_valid),
    .hit   (hit)
  );

  always_comb begin
    state_next   = state;
    dest_next    = dest;
    rd_cnt_next  = rd_cnt;
    cmp_vld_next = 1'b0;
    cmp_idx_next = cmp_idx;
    pend_next    = pend;
    load         = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          pend_next   = '0;
          dest_next   = in_data.address;
          rd_cnt_next = '0;
          if (in_data.action == ACT_WRITE) begin
            state_next = S_DONE;
          end else if (in_data.address == own_address) begin
            pend_next.for_self = 1'b1;
            state_next         = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // issue the next read while the previous entry is compared
        if (rd_cnt < CW'(ENTRIES)) begin
          cmp_vld_next = 1'b1;
          rd_cnt_next  = rd_cnt + CW'(1);
        end
        cmp_idx_next = rd_cnt[SW-1:0];
        if (cmp_vld && hit) begin
          pend_next.route_found  = 1'b1;
          pend_next.matched_slot = SLOT_W'(cmp_idx);
          pend_next.out_port     = rd_entry.port;
          pend_next.next_hop     = rd_entry.has_gw ? rd_entry.gateway : dest;
          cmp_vld_next           = 1'b0;
          state_next             = S_DONE;
        end else if (cmp_vld && (cmp_idx == SW'(ENTRIES - 1))) begin
          cmp_vld_next = 1'b0;
          state_next   = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid || !out_stall) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cmp_vld     <= 1'b0;
      out_valid   <= 1'b0;
      own_address <= '0;
    end else begin
      state     <= state_next;
      cmp_vld   <= cmp_vld_next;
      out_valid <= load || (out_valid && out_stall);
      if (cfg_valid && cfg_ready) begin
        own_address <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    dest    <= dest_next;
    rd_cnt  <= rd_cnt_next;
    cmp_idx <= cmp_idx_next;
    pend    <= pend_next;
    if (load) begin
      out_data <= pend;
    end
  end

  assign self_route = out_data.for_self && out_data.route_found;
  assign miss_clean = out_data.route_found
                      || ((out_data.next_hop == '0) && (out_data.out_port == '0)
                          && (out_data.matched_slot == '0));
  assign done_held  = (state == S_DONE) && out_valid && out_stall;

  `RTLK_ASSERT_NOW(a_cmp_in_scan, cmp_vld, state == S_SCAN, "compare busy outside scan")
  `RTLK_ASSERT_NOW(a_self_no_route, out_valid, !self_route, "self delivery with a route")
  `RTLK_ASSERT_NOW(a_miss_zero, out_valid, miss_clean, "miss carries route fields")
  `RTLK_ASSERT_NEXT(a_done_hold, done_held, state == S_DONE, "result dropped while stalled")

endmodule

`default_nettype wire

/* hdl/rtlk_table.sv */
`default_nettype none

module rtlk_table #(
  parameter int ENTRIES = rtlk_pkg::ENTRIES_DEF,
  parameter int SW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire rtlk_pkg::wr_t   wr,
  input  wire logic [SW-1:0]   rd_addr,
  output rtlk_pkg::entry_t     rd_entry,
  output logic                 rd_valid
);
  import rtlk_pkg::*;

  entry_t           mem [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [SW-1:0]    wr_idx;

  assign wr_idx = SW'(wr.slot);

  // Route fields: no reset, only used once the slot is marked valid.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_idx] <= wr.entry;
    end
    rd_entry <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr_idx] <= wr.mark;
      end
      rd_valid <= (int'(rd_addr) < ENTRIES) ? valid[rd_addr] : 1'b0;
    end
  end

endmodule

`default_nettype wire

/* hdl/rtlk_cmp.sv */
`default_nettype none

module rtlk_cmp (
  input  wire logic [rtlk_pkg::ADDR_W-1:0] addr,
  input  wire rtlk_pkg::entry_t            entry,
  input  wire logic                        valid,
  output logic                             hit
);
  import rtlk_pkg::*;

  logic [ADDR_W-1:0] mask;

  // Keep only the leading whole octets of the prefix.
  always_comb begin
    if (entry.octets == '0) begin
      mask = '0;
    end else if (int'(entry.octets) >= ADDR_OCTETS) begin
      mask = '1;
    end else begin
      mask = {ADDR_W{1'b1}} << (ADDR_W - OCTET_BITS * int'(entry.octets));
    end
  end

  assign hit = valid && (((addr ^ entry.prefix) & mask) == '0);

endmodule

`default_nettype wire

/* sim/tb_ipv4_route_table_lookup_top.sv */
`default_nettype none

module tb_ipv4_route_table_lookup_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rtlk_pkg::*;

  localparam int TABLE_SIZE  = ENTRIES_DEF;
  localparam int PORT_COUNT  = PORTS_DEF;
  localparam int SCAN_CYCLES = TABLE_SIZE + 3;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_t               in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_t              out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [ADDR_W-1:0] cfg_data  = '0;

  // Own copy of the forwarding table and the router address.
  logic              fib_valid  [TABLE_SIZE];
  logic [ADDR_W-1:0] fib_prefix [TABLE_SIZE];
  logic [OCT_W-1:0]  fib_octets [TABLE_SIZE];
  logic              fib_has_gw [TABLE_SIZE];
  logic [ADDR_W-1:0] fib_gateway[TABLE_SIZE];
  logic [PORT_W-1:0] fib_port   [TABLE_SIZE];
  logic [ADDR_W-1:0] router_addr;

  out_t pending_routes[$];
  int   fail_count  = 0;
  int   cycle_count = 0;
  int   hold_left   = 0;
  bit   no_idle     = 1'b0;

  ipv4_route_table_lookup_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_ipv4_route_table_lookup_top: FAIL");
      $finish;
    end
  end

  function automatic int pick_wait();
    if (no_idle || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 15);
  endfunction

  function automatic logic [ADDR_W-1:0] octet_mask(input int octets);
    case (octets)
      0:       return 32'h0000_0000;
      1:       return 32'hFF00_0000;
      2:       return 32'hFFFF_0000;
      3:       return 32'hFFFF_FF00;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic out_t predict_route(input in_t item);
    out_t             r;
    int               n;
    logic [PORT_W-1:0] p;
    r = '0;
    if (item.action == ACT_WRITE) begin
      n = item.prefix_length / OCTET_BITS;
      if (n > ADDR_OCTETS) n = ADDR_OCTETS;
      p = (item.egress_port >= PORT_COUNT) ? PORT_W'(PORT_COUNT - 1) : item.egress_port;
      if (item.entry_slot < TABLE_SIZE) begin
        fib_prefix[item.entry_slot]  = item.address;
        fib_octets[item.entry_slot]  = OCT_W'(n);
        fib_has_gw[item.entry_slot]  = item.gateway_given;
        fib_gateway[item.entry_slot] = item.gateway_address;
        fib_port[item.entry_slot]    = p;
        fib_valid[item.entry_slot]   = item.entry_enable;
      end
      return r;
    end
    if (item.address == router_addr) begin
      r.for_self = 1'b1;
      return r;
    end
    // Lowest slot wins.
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (!r.route_found && fib_valid[i] &&
          ((item.address ^ fib_prefix[i]) & octet_mask(fib_octets[i])) == '0) begin
        r.route_found  = 1'b1;
        r.matched_slot = SLOT_W'(i);
        r.out_port     = fib_port[i];
        r.next_hop     = fib_has_gw[i] ? fib_gateway[i] : item.address;
      end
    end
    return r;
  endfunction

  function automatic string route_text(input out_t r);
    return $sformatf("self=%0d found=%0d slot=%0d port=%0d hop=%h",
                     r.for_self, r.route_found, r.matched_slot, r.out_port, r.next_hop);
  endfunction

  task automatic note_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // Result sink: hold off a random number of cycles after each beat.
  always @(posedge clk) begin : sink_ctl
    int w;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (out_valid && !out_stall) begin
      w = pick_wait();
      hold_left <= w;
      out_stall <= (w != 0);
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end
  end

  always @(posedge clk) begin : result_check
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_routes.size() == 0) begin
        note_fail({"result with nothing pending: ", route_text(out_data)});
      end else begin
        want = pending_routes.pop_front();
        if (out_data.for_self !== want.for_self || out_data.route_found !== want.route_found ||
            out_data.matched_slot !== want.matched_slot ||
            out_data.out_port !== want.out_port || out_data.next_hop !== want.next_hop)
          note_fail({"expected ", route_text(want), " got ", route_text(out_data)});
      end
    end
  end

  task automatic offer_item(input in_t item);
    int gap;
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_routes.push_back(predict_route(item));
    gap = pick_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait for every pending result.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_routes.size() != 0) @(posedge clk);
  endtask

  task automatic load_own_address(input logic [ADDR_W-1:0] addr);
    settle();
    cfg_data  <= addr;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    router_addr = addr;
  endtask

  function automatic in_t make_item(input action_t act, input logic [ADDR_W-1:0] addr,
                                    input int slot, input int len, input bit gw_given,
                                    input logic [ADDR_W-1:0] gw, input int port,
                                    input bit en);
    in_t it;
    it.action          = act;
    it.address         = addr;
    it.entry_slot      = SLOT_W'(slot);
    it.prefix_length   = LEN_W'(len);
    it.gateway_given   = gw_given;
    it.gateway_address = gw;
    it.egress_port     = PORT_W'(port);
    it.entry_enable    = en;
    return it;
  endfunction

  function automatic in_t lookup_of(input logic [ADDR_W-1:0] addr);
    return make_item(ACT_LOOKUP, addr, 0, 0, 1'b0, '0, 0, 1'b0);
  endfunction

  // Keep a random number of leading octets of base, randomise the rest.
  function automatic logic [ADDR_W-1:0] near_address(input logic [ADDR_W-1:0] base);
    logic [ADDR_W-1:0] keep;
    keep = octet_mask($urandom_range(0, 4));
    return (base & keep) | ($urandom() & ~keep);
  endfunction

  function automatic in_t random_route_item();
    in_t         it;
    int          pick;
    logic [7:0]  lead;
    it.action          = ($urandom_range(0, 9) < 3) ? ACT_WRITE : ACT_LOOKUP;
    it.address         = $urandom();
    it.entry_slot      = SLOT_W'($urandom_range(0, 7));
    it.prefix_length   = LEN_W'($urandom_range(0, 63));
    it.gateway_given   = 1'($urandom_range(0, 1));
    it.gateway_address = $urandom();
    it.egress_port     = PORT_W'($urandom_range(0, 15));
    it.entry_enable    = ($urandom_range(0, 6) != 0);
    pick = $urandom_range(0, 99);
    if (it.action == ACT_WRITE) begin
      // Crowd prefixes into a few networks so entries overlap.
      case ($urandom_range(0, 3))
        0:       lead = 8'd10;
        1:       lead = 8'd172;
        2:       lead = 8'd192;
        default: lead = 8'($urandom());
      endcase
      it.address[31:24] = lead;
      it.address[23:16] = 8'($urandom_range(0, 3));
      if (pick < 70)
        it.prefix_length = ($urandom_range(0, 9) == 0) ? LEN_W'(0)
                                                        : LEN_W'(8 * $urandom_range(1, 4));
    end else if (pick < 60) begin
      it.address = near_address(fib_prefix[$urandom_range(0, TABLE_SIZE - 1)]);
    end else if (pick < 70) begin
      it.address = router_addr;
    end else if (pick < 85) begin
      it.address = {8'd10, 8'($urandom_range(0, 3)), 16'($urandom())};
    end
    return it;
  endfunction

  task automatic test_empty_table();
    offer_item(lookup_of(32'h0000_0000));
    offer_item(lookup_of(32'hFFFF_FFFF));
    offer_item(lookup_of($urandom()));
  endtask

  task automatic test_route_writes();
    offer_item(make_item(ACT_WRITE, 32'hC0A8_014D, 4, 32, 1'b0, 32'h0, 15, 1'b1));
    offer_item(make_item(ACT_WRITE, 32'h0A00_0000, 2, 8, 1'b1, 32'hFFFF_FFFF, 3, 1'b1));
    offer_item(make_item(ACT_WRITE, 32'h0A14_0000, 1, 23, 1'b0, 32'h0, 0, 1'b1));
    offer_item(make_item(ACT_WRITE, 32'h0000_0000, 7, 0, 1'b1, 32'h0102_0304, 9, 1'b1));
    offer_item(lookup_of(32'h0A14_6301));
    offer_item(lookup_of(32'h0A63_0001));
    offer_item(lookup_of(32'hC0A8_014D));
    offer_item(lookup_of(32'hC0A8_014E));
    // Length above 32 compares the whole address.
    offer_item(make_item(ACT_WRITE, 32'hAC10_0509, 3, 63, 1'b1, 32'h0A0A_0A0A, 7, 1'b1));
    offer_item(lookup_of(32'hAC10_0509));
    offer_item(lookup_of(32'hAC10_0508));
    offer_item(make_item(ACT_WRITE, 32'h0A00_0000, 2, 8, 1'b1, 32'hFFFF_FFFF, 3, 1'b0));
    offer_item(lookup_of(32'h0A63_0001));
    // Under one whole octet: matches every destination.
    offer_item(make_item(ACT_WRITE, 32'h5A5A_5A5A, 0, 7, 1'b0, 32'h0, 12, 1'b1));
    offer_item(lookup_of(32'hFFFF_FFFF));
  endtask

  task automatic test_own_address();
    load_own_address(32'hFFFF_FFFF);
    offer_item(lookup_of(32'hFFFF_FFFF));
    offer_item(lookup_of(32'h0000_0000));
    load_own_address(32'h0A14_0304);
    offer_item(lookup_of(32'h0A14_0304));
    offer_item(make_item(ACT_WRITE, 32'h0A14_0304, 6, 32, 1'b1, 32'h0, 5, 1'b1));
    offer_item(lookup_of(32'h0A14_0305));
  endtask

  task automatic test_random_traffic(input int count, input bit burst, input int pause_at);
    no_idle = burst;
    for (int i = 0; i < count; i++) begin
      if (i == pause_at) settle();
      offer_item(random_route_item());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < TABLE_SIZE; i++) begin
      fib_valid[i]   = 1'b0;
      fib_prefix[i]  = '0;
      fib_octets[i]  = '0;
      fib_has_gw[i]  = 1'b0;
      fib_gateway[i] = '0;
      fib_port[i]    = '0;
    end
    router_addr = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_route_writes();
    test_own_address();

    load_own_address($urandom());
    test_random_traffic(500, 1'b0, 250);
    load_own_address(32'hFFFF_FFFF);
    test_random_traffic(300, 1'b1, -1);
    load_own_address(32'h0000_0000);
    test_random_traffic(400, 1'b0, 120);
    load_own_address({8'd192, 8'd1, 16'($urandom())});
    test_random_traffic(325, 1'b0, -1);

    settle();
    repeat (SCAN_CYCLES + 5) @(posedge clk);
    if (fail_count == 0 && pending_routes.size() == 0) begin
      $display("tb_ipv4_route_table_lookup_top: PASS");
    end else begin
      $display("tb_ipv4_route_table_lookup_top: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
